### rtl/mmp_pkg.sv
// Package for the MIDI message parser: status byte constants, event codes,
// the result record and the decode helpers. No dependencies.
package mmp_pkg;

  localparam logic [7:0] RealtimeMin   = 8'hF8;
  localparam logic [7:0] SysexStart    = 8'hF0;
  localparam logic [7:0] SysCommonMin  = 8'hF1;
  localparam logic [3:0] HiNoteOff     = 4'h8;
  localparam logic [3:0] HiNoteOn      = 4'h9;
  localparam logic [3:0] HiControl     = 4'hB;
  localparam logic [3:0] HiProgram     = 4'hC;
  localparam logic [3:0] HiPressure    = 4'hD;
  localparam logic [15:0] CountMax     = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_NOTE_ON  = 3'd2,
    EV_CONTROL  = 3'd3,
    EV_PROGRAM  = 3'd4
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [15:0] sysex_bytes;
    logic [15:0] sysex_msgs;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CountMax) ? v : v + 16'd1;
  endfunction

  // Decodes a completed channel message; counters are left at zero.
  function automatic result_t emit(input logic [7:0] st, input logic [6:0] a,
                                   input logic [6:0] b);
    result_t r;
    r = '0;
    r.kind = EV_NONE;
    unique case (st[7:4])
      HiNoteOff: r.kind = EV_NOTE_OFF;
      HiNoteOn: begin
        if (b != 7'd0) begin
          r.kind = EV_NOTE_ON;
          r.second_data = b;
        end else begin
          r.kind = EV_NOTE_OFF;
        end
      end
      HiControl: begin
        r.kind = EV_CONTROL;
        r.second_data = b;
      end
      HiProgram: r.kind = EV_PROGRAM;
      default: r.kind = EV_NONE;
    endcase
    if (r.kind != EV_NONE) begin
      r.channel = st[3:0];
      r.first_data = a;
    end
    return r;
  endfunction

endpackage

### rtl/midi_message_parser.sv
// MIDI message parser: one byte per transaction in, one result per transaction out.
// The byte is registered, decoded, and the result registered. Throughput is
// one byte per cycle while results are taken; the input register and the result
// register let a new byte enter while an earlier result waits to be taken.
// Reset is asynchronous and active low; it clears running status, SysEx mode
// and both SysEx counters. Depends on mmp_pkg and mmp_core.
module midi_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic [15:0] sysex_byte_count_o,
  output logic [15:0] sysex_message_count_o
);
  import mmp_pkg::*;

  logic    in_vld_q;
  logic [7:0] in_byte_q;
  logic    out_vld_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  mmp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign event_kind_o          = 3'(out_q.kind);
  assign channel_o             = out_q.channel;
  assign first_data_o          = out_q.first_data;
  assign second_data_o         = out_q.second_data;
  assign sysex_byte_count_o    = out_q.sysex_bytes;
  assign sysex_message_count_o = out_q.sysex_msgs;

endmodule

### rtl/mmp_core.sv
// Parser state and per-byte decode: running status, held data byte and the
// SysEx skip mode with its saturating counters. Depends on mmp_pkg.
module mmp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output mmp_pkg::result_t result_o
);
  import mmp_pkg::*;

  logic [7:0]  status_q, status_d;
  logic [6:0]  held_q, held_d;
  logic [1:0]  needed_q, needed_d;
  logic        have_q, have_d;
  logic        sysex_q, sysex_d;
  logic [15:0] sx_bytes_q, sx_bytes_d;
  logic [15:0] sx_msgs_q, sx_msgs_d;
  logic [15:0] bytes_tmp;
  logic        go;
  result_t     res;

  always_comb begin
    status_d   = status_q;
    held_d     = held_q;
    needed_d   = needed_q;
    have_d     = have_q;
    sysex_d    = sysex_q;
    sx_bytes_d = sx_bytes_q;
    sx_msgs_d  = sx_msgs_q;
    bytes_tmp  = sx_bytes_q;
    go         = 1'b0;
    res        = '0;
    res.kind   = EV_NONE;
    if (byte_i < RealtimeMin) begin
      go = 1'b1;
      if (sysex_q) begin
        bytes_tmp = sat_inc(sx_bytes_q);
        if (byte_i[7]) begin
          sysex_d = 1'b0;
        end else begin
          go = 1'b0;
        end
      end
      sx_bytes_d = bytes_tmp;
      if (go) begin
        if (byte_i[7]) begin
          priority if (byte_i == SysexStart) begin
            sysex_d    = 1'b1;
            sx_msgs_d  = sat_inc(sx_msgs_q);
            sx_bytes_d = sat_inc(bytes_tmp);
            status_d   = '0;
            needed_d   = '0;
            have_d     = 1'b0;
          end else if (byte_i >= SysCommonMin) begin
            status_d = '0;
            needed_d = '0;
            have_d   = 1'b0;
          end else begin
            status_d = byte_i;
            needed_d = (byte_i[7:4] == HiProgram || byte_i[7:4] == HiPressure)
                       ? 2'd1 : 2'd2;
            have_d   = 1'b0;
          end
        end else if (status_q != 8'd0) begin
          if (!have_q && needed_q != 2'd0) begin
            held_d = byte_i[6:0];
            if (needed_q == 2'd1) begin
              res = emit(status_q, byte_i[6:0], 7'd0);
            end else begin
              have_d = 1'b1;
            end
          end else if (have_q) begin
            res    = emit(status_q, held_q, byte_i[6:0]);
            have_d = 1'b0;
          end
        end
      end
    end
    res.sysex_bytes = sx_bytes_d;
    res.sysex_msgs  = sx_msgs_d;
    result_o = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= '0;
      held_q     <= '0;
      needed_q   <= '0;
      have_q     <= 1'b0;
      sysex_q    <= 1'b0;
      sx_bytes_q <= '0;
      sx_msgs_q  <= '0;
    end else if (step_i) begin
      status_q   <= status_d;
      held_q     <= held_d;
      needed_q   <= needed_d;
      have_q     <= have_d;
      sysex_q    <= sysex_d;
      sx_bytes_q <= sx_bytes_d;
      sx_msgs_q  <= sx_msgs_d;
    end
  end

endmodule
